/* design/rlkd_pkg.sv */
// ----------------------------------------------------------------------------
// rlkd_pkg
// Shared constants, codes and helpers for the resistor-ladder key decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package rlkd_pkg;

  // Converter and level widths
  localparam int ADC_BITS   = 10;
  localparam int LEVEL_BITS = 10;
  localparam int LEVEL_SLOTS = 3;
  localparam int CMP_W = ((ADC_BITS > LEVEL_BITS) ? ADC_BITS : LEVEL_BITS) + 2;

  // Register widths
  localparam int REL_W    = 10;
  localparam int TOL_W    = 6;
  localparam int MS_W     = 16;
  localparam int LEVELS_W = LEVEL_BITS * LEVEL_SLOTS;
  localparam int TIME_W   = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = LEVELS_W;

  // Result fields
  localparam int KIND_W = 3;
  localparam int KEY_W  = 2;
  localparam int CODE_W = 6;

  localparam int DEBOUNCE_WINDOW_MS = 10;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_RELEASE_LEVEL     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MATCH_TOLERANCE   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE_MS       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_LONG_PRESS_MS     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SINGLE_KEY_LEVELS = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_COMBO_LEVELS      = 3'd5;

  // Register reset values
  localparam logic [REL_W-1:0]    RST_RELEASE_LEVEL     = 10'd650;
  localparam logic [TOL_W-1:0]    RST_MATCH_TOLERANCE   = 6'd2;
  localparam logic [MS_W-1:0]     RST_DEBOUNCE_MS       = 16'd50;
  localparam logic [MS_W-1:0]     RST_LONG_PRESS_MS     = 16'd2000;
  localparam logic [LEVELS_W-1:0] RST_SINGLE_KEY_LEVELS = 30'd231845946;
  localparam logic [LEVELS_W-1:0] RST_COMBO_LEVELS      = 30'd86033447;

  // Press phase codes
  localparam logic [1:0] PH_IDLE  = 2'd0;
  localparam logic [1:0] PH_SHORT = 2'd1;
  localparam logic [1:0] PH_LONG  = 2'd2;

  // Internal event code is CODE_STEP * kind + key
  localparam int CODE_STEP = 10;
  localparam logic [CODE_W-1:0] CODE_NONE       = 6'd0;
  localparam logic [CODE_W-1:0] CODE_HELD_BASE  = 6'd10;
  localparam logic [CODE_W-1:0] CODE_HOLD_BASE  = 6'd30;
  localparam logic [CODE_W-1:0] CODE_LATCH_LONG = 6'd40;
  localparam logic [CODE_W-1:0] CODE_COMBO_BASE = 6'd50;

  // Split an event code into its kind (code / 10)
  function automatic logic [KIND_W-1:0] code_kind(input logic [CODE_W-1:0] c);
    logic [KIND_W-1:0] k;
    k = '0;
    for (int n = 1; n < (1 << CODE_W) / CODE_STEP + 1; n++) begin
      if (c >= CODE_W'(CODE_STEP * n)) k = KIND_W'(n);
    end
    return k;
  endfunction

  // Key part of an event code (code % 10), truncated to the key field
  function automatic logic [KEY_W-1:0] code_key(input logic [CODE_W-1:0] c);
    logic [KIND_W-1:0] k;
    logic [CODE_W-1:0] r;
    k = code_kind(c);
    r = c - CODE_W'(CODE_STEP * int'(k));
    return r[KEY_W-1:0];
  endfunction

endpackage

`default_nettype wire

/* design/rlkd_in_if.sv */
// ----------------------------------------------------------------------------
// rlkd_in_if
// Sample channel: converter reading and millisecond time.
// ----------------------------------------------------------------------------
`default_nettype none

interface rlkd_in_if;
  logic                             valid;
  logic                             ready;
  logic [rlkd_pkg::ADC_BITS-1:0]    adc_sample;
  logic [rlkd_pkg::TIME_W-1:0]      now_ms;

  modport source (output valid, output adc_sample, output now_ms, input ready);
  modport sink   (input valid, input adc_sample, input now_ms, output ready);
endinterface

`default_nettype wire

/* design/rlkd_out_if.sv */
// ----------------------------------------------------------------------------
// rlkd_out_if
// Event channel: event kind and key number.
// ----------------------------------------------------------------------------
`default_nettype none

interface rlkd_out_if;
  logic                           valid;
  logic                           ready;
  logic [rlkd_pkg::KIND_W-1:0]    event_kind;
  logic [rlkd_pkg::KEY_W-1:0]     key_number;

  modport source (output valid, output event_kind, output key_number, input ready);
  modport sink   (input valid, input event_kind, input key_number, output ready);
endinterface

`default_nettype wire

/* design/rlkd_cfg_if.sv */
// ----------------------------------------------------------------------------
// rlkd_cfg_if
// Register write channel: index and data.
// ----------------------------------------------------------------------------
`default_nettype none

interface rlkd_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [rlkd_pkg::CFG_IDX_W-1:0]    index;
  logic [rlkd_pkg::CFG_DATA_W-1:0]   data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

/* design/rlkd_match.sv */
// ----------------------------------------------------------------------------
// rlkd_match
// Match a sample against three packed levels; first exclusive hit wins.
// ----------------------------------------------------------------------------
`default_nettype none

module rlkd_match (
  input  wire logic [rlkd_pkg::ADC_BITS-1:0] sample,
  input  wire logic [rlkd_pkg::LEVELS_W-1:0] levels,
  input  wire logic [rlkd_pkg::TOL_W-1:0]    tol,
  output logic      [1:0]                    slot
);

  logic signed [rlkd_pkg::CMP_W-1:0] s_w;
  logic signed [rlkd_pkg::CMP_W-1:0] t_w;
  logic        [rlkd_pkg::LEVEL_SLOTS-1:0] hit;

  assign s_w = rlkd_pkg::CMP_W'(sample);
  assign t_w = rlkd_pkg::CMP_W'(tol);

  // One window per lane: level - tol < sample < level + tol
  always_comb begin
    logic signed [rlkd_pkg::CMP_W-1:0] lvl;
    for (int i = 0; i < rlkd_pkg::LEVEL_SLOTS; i++) begin
      lvl = rlkd_pkg::CMP_W'(levels[i*rlkd_pkg::LEVEL_BITS +: rlkd_pkg::LEVEL_BITS]);
      hit[i] = (s_w > lvl - t_w) && (s_w < lvl + t_w);
    end
  end

  always_comb begin
    priority if (hit[0]) begin
      slot = 2'd1;
    end else if (hit[1]) begin
      slot = 2'd2;
    end else if (hit[2]) begin
      slot = 2'd3;
    end else begin
      slot = 2'd0;
    end
  end

endmodule

`default_nettype wire

/* design/resistor_ladder_key_decoder_top.sv */
// ----------------------------------------------------------------------------
// resistor_ladder_key_decoder_top
// Keypad decoder for a resistor-ladder line: debounce, latch, long hold,
// two-key combinations and release reporting, one event per sample.
// ----------------------------------------------------------------------------
//
//   channel   dir   handshake      payload
//   in_chan   in    valid/ready    adc_sample[9:0], now_ms[31:0]
//   out_chan  out   valid/ready    event_kind[2:0], key_number[1:0]
//   cfg_chan  in    valid/ready    index[2:0], data[29:0]
//
// Each sample is a transfer into an input register; the decision logic and
// the press state update sit between that register and the result register,
// so each sample leaves as one event from the result register.
// One sample per cycle is sustained while out_chan takes every event; the
// state loop (start time, phase, latched code) updates with each sample.
// A stalled output holds the event and the input register; in_chan.ready
// drops only when both are full. Reset clears valids and state; presets registers.
// cfg_chan is always ready; write registers only while no sample is in flight.
// ----------------------------------------------------------------------------
`default_nettype none

module resistor_ladder_key_decoder_top (
  input  wire logic   clk,
  input  wire logic   rst_n,
  rlkd_in_if.sink     in_chan,
  rlkd_out_if.source  out_chan,
  rlkd_cfg_if.sink    cfg_chan
);

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [rlkd_pkg::REL_W-1:0]    release_level_r;
  logic [rlkd_pkg::TOL_W-1:0]    match_tolerance_r;
  logic [rlkd_pkg::MS_W-1:0]     debounce_ms_r;
  logic [rlkd_pkg::MS_W-1:0]     long_press_ms_r;
  logic [rlkd_pkg::LEVELS_W-1:0] single_levels_r;
  logic [rlkd_pkg::LEVELS_W-1:0] combo_levels_r;

  assign cfg_chan.ready = 1'b1;

  // Writes beyond the last register index are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      release_level_r   <= rlkd_pkg::RST_RELEASE_LEVEL;
      match_tolerance_r <= rlkd_pkg::RST_MATCH_TOLERANCE;
      debounce_ms_r     <= rlkd_pkg::RST_DEBOUNCE_MS;
      long_press_ms_r   <= rlkd_pkg::RST_LONG_PRESS_MS;
      single_levels_r   <= rlkd_pkg::RST_SINGLE_KEY_LEVELS;
      combo_levels_r    <= rlkd_pkg::RST_COMBO_LEVELS;
    end else if (cfg_chan.valid) begin
      unique case (cfg_chan.index)
        rlkd_pkg::CFG_RELEASE_LEVEL:     release_level_r   <= cfg_chan.data[rlkd_pkg::REL_W-1:0];
        rlkd_pkg::CFG_MATCH_TOLERANCE:   match_tolerance_r <= cfg_chan.data[rlkd_pkg::TOL_W-1:0];
        rlkd_pkg::CFG_DEBOUNCE_MS:       debounce_ms_r     <= cfg_chan.data[rlkd_pkg::MS_W-1:0];
        rlkd_pkg::CFG_LONG_PRESS_MS:     long_press_ms_r   <= cfg_chan.data[rlkd_pkg::MS_W-1:0];
        rlkd_pkg::CFG_SINGLE_KEY_LEVELS: single_levels_r   <= cfg_chan.data;
        rlkd_pkg::CFG_COMBO_LEVELS:      combo_levels_r    <= cfg_chan.data;
        default: begin
        end
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Pipeline control: input register -> result register
  // --------------------------------------------------------------------------
  logic                            s1_valid_r;
  logic [rlkd_pkg::ADC_BITS-1:0]   s1_sample_r;
  logic [rlkd_pkg::TIME_W-1:0]     s1_now_r;
  logic                            out_valid_r;
  logic [rlkd_pkg::KIND_W-1:0]     out_kind_r;
  logic [rlkd_pkg::KEY_W-1:0]      out_key_r;
  logic                            advance;
  logic                            s1_fire;
  logic                            in_fire;

  // Advance the input register whenever the result register is free or drains
  assign advance       = !out_valid_r || out_chan.ready;
  assign s1_fire       = s1_valid_r && advance;
  assign in_chan.ready = !s1_valid_r || advance;
  assign in_fire       = in_chan.valid && in_chan.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_chan.ready) begin
      s1_valid_r <= in_chan.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_sample_r <= in_chan.adc_sample;
      s1_now_r    <= in_chan.now_ms;
    end
  end

  // --------------------------------------------------------------------------
  // Press state
  // --------------------------------------------------------------------------
  logic [rlkd_pkg::TIME_W-1:0]  start_r, start_nxt;
  logic [1:0]                   phase_r, phase_nxt;
  logic [rlkd_pkg::CODE_W-1:0]  latched_r, latched_nxt;
  logic [rlkd_pkg::CODE_W-1:0]  res_code;

  // --------------------------------------------------------------------------
  // Decision logic
  // --------------------------------------------------------------------------
  logic signed [rlkd_pkg::CMP_W-1:0] s_w;
  logic signed [rlkd_pkg::CMP_W-1:0] rel_thr;
  logic                              released;
  logic [rlkd_pkg::TIME_W-1:0]       elapsed;
  logic [rlkd_pkg::MS_W:0]           deb_end;
  logic                              long_hit;
  logic                              deb_hit;
  logic [1:0]                        single_k;
  logic [1:0]                        combo_k;

  assign s_w     = rlkd_pkg::CMP_W'(s1_sample_r);
  assign rel_thr = rlkd_pkg::CMP_W'(release_level_r) - rlkd_pkg::CMP_W'(match_tolerance_r);
  assign released = s_w > rel_thr;

  // Elapsed time wraps modulo 2^32
  assign elapsed  = s1_now_r - start_r;
  assign deb_end  = (rlkd_pkg::MS_W+1)'(debounce_ms_r)
                  + (rlkd_pkg::MS_W+1)'(rlkd_pkg::DEBOUNCE_WINDOW_MS);
  assign long_hit = elapsed > rlkd_pkg::TIME_W'(long_press_ms_r);
  assign deb_hit  = (elapsed > rlkd_pkg::TIME_W'(debounce_ms_r))
                 && (elapsed < rlkd_pkg::TIME_W'(deb_end));

  rlkd_match u_single (
    .sample (s1_sample_r),
    .levels (single_levels_r),
    .tol    (match_tolerance_r),
    .slot   (single_k)
  );

  rlkd_match u_combo (
    .sample (s1_sample_r),
    .levels (combo_levels_r),
    .tol    (match_tolerance_r),
    .slot   (combo_k)
  );

  always_comb begin
    start_nxt   = start_r;
    phase_nxt   = phase_r;
    latched_nxt = latched_r;
    res_code    = rlkd_pkg::CODE_NONE;
    priority if (released) begin
      // Release: restart the timer and report any pending press
      start_nxt = s1_now_r;
      if (phase_r == rlkd_pkg::PH_SHORT) begin
        phase_nxt   = rlkd_pkg::PH_IDLE;
        latched_nxt = latched_r + rlkd_pkg::CODE_HELD_BASE;
        res_code    = latched_r + rlkd_pkg::CODE_HELD_BASE;
      end else if (phase_r == rlkd_pkg::PH_LONG) begin
        phase_nxt = rlkd_pkg::PH_IDLE;
        res_code  = latched_r;
      end
    end else if (long_hit) begin
      // Long hold of a latched key, else try the combination levels
      phase_nxt = rlkd_pkg::PH_LONG;
      if (latched_r != rlkd_pkg::CODE_NONE && single_k != 2'd0) begin
        latched_nxt = rlkd_pkg::CODE_LATCH_LONG + rlkd_pkg::CODE_W'(single_k);
        res_code    = rlkd_pkg::CODE_HOLD_BASE + rlkd_pkg::CODE_W'(single_k);
      end else if (latched_r < rlkd_pkg::CODE_LATCH_LONG && combo_k != 2'd0) begin
        latched_nxt = rlkd_pkg::CODE_NONE;
        res_code    = rlkd_pkg::CODE_COMBO_BASE + rlkd_pkg::CODE_W'(combo_k);
      end
    end else if (deb_hit) begin
      // Debounce window: latch the key under the sample
      phase_nxt   = rlkd_pkg::PH_SHORT;
      latched_nxt = (single_k != 2'd0)
                  ? rlkd_pkg::CODE_HELD_BASE + rlkd_pkg::CODE_W'(single_k)
                  : rlkd_pkg::CODE_NONE;
    end else begin
      // Outside the windows: repeat a pending short press on every poll
      if (phase_r == rlkd_pkg::PH_SHORT) begin
        res_code = latched_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_r   <= '0;
      phase_r   <= rlkd_pkg::PH_IDLE;
      latched_r <= rlkd_pkg::CODE_NONE;
    end else if (s1_fire) begin
      start_r   <= start_nxt;
      phase_r   <= phase_nxt;
      latched_r <= latched_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Result register
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      out_kind_r <= rlkd_pkg::code_kind(res_code);
      out_key_r  <= rlkd_pkg::code_key(res_code);
    end
  end

  assign out_chan.valid      = out_valid_r;
  assign out_chan.event_kind = out_kind_r;
  assign out_chan.key_number = out_key_r;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && out_valid_r && !out_chan.ready |-> !in_chan.ready)
    else $error("input taken while both stages are stalled");

  a_out_from_stage: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(s1_valid_r))
    else $error("event appeared without a sample in the input register");

  a_release_idles: assert property (@(posedge clk) disable iff (!rst_n)
    s1_fire && released |=> phase_r == rlkd_pkg::PH_IDLE)
    else $error("phase not idle after a release");

  a_release_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    s1_fire && released |=> start_r == $past(s1_now_r))
    else $error("press timer not restarted on release");

  a_phase_legal: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r != 2'd3)
    else $error("press phase reached an unused code");

endmodule

`default_nettype wire

/* tb/tb_resistor_ladder_key_decoder_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_resistor_ladder_key_decoder_top
// Self-checking bench for the resistor-ladder key decoder. A table of
// directed samples is followed by random press gestures under several
// register settings. Every sample transfer runs through a local model of the
// decoder, and each event transfer is checked against the oldest prediction.
// ----------------------------------------------------------------------------

module tb_resistor_ladder_key_decoder_top;
  import rlkd_pkg::*;

  localparam int N_SETTINGS        = 8;
  localparam int SAMPLES_PER_SETUP = 205;
  localparam int HOLD_OFF_CYCLES   = 80;
  localparam int SETTLE_CYCLES     = 4;
  localparam int STALL_LIMIT       = 2000;

  // Event kinds carried on the result channel
  localparam logic [KIND_W-1:0] EV_NONE      = 3'd0;
  localparam logic [KIND_W-1:0] EV_HELD      = 3'd1;
  localparam logic [KIND_W-1:0] EV_SHORT_REL = 3'd2;
  localparam logic [KIND_W-1:0] EV_LONG_HOLD = 3'd3;
  localparam logic [KIND_W-1:0] EV_LONG_REL  = 3'd4;
  localparam logic [KIND_W-1:0] EV_COMBO     = 3'd5;

  // Register indexes with no register behind them
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [KEY_W-1:0]  key;
  } key_event_t;

  typedef struct packed {
    logic [ADC_BITS-1:0] adc;
    logic [TIME_W-1:0]   now;
    bit                  typed;
    logic [KIND_W-1:0]   kind;
    logic [KEY_W-1:0]    key;
  } ladder_row_t;

  // Directed samples under the reset settings: keys at 58/108/221, pairs at
  // 39/49/82, tolerance 2, release above 648, latch window 51..59 ms,
  // long hold beyond 2000 ms.
  localparam ladder_row_t DIRECTED_ROWS [25] = '{
    '{10'd1023, 32'd0,          1'b1, EV_NONE,      2'd0}, // release straight after reset
    '{10'd58,   32'd30,         1'b1, EV_NONE,      2'd0}, // still bouncing
    '{10'd58,   32'd55,         1'b0, EV_NONE,      2'd0}, // latch key 1
    '{10'd58,   32'd100,        1'b0, EV_NONE,      2'd0}, // held key 1
    '{10'd1023, 32'd120,        1'b0, EV_NONE,      2'd0}, // short release key 1
    '{10'd108,  32'd175,        1'b0, EV_NONE,      2'd0}, // latch key 2
    '{10'd108,  32'd2200,       1'b0, EV_NONE,      2'd0}, // long hold key 2
    '{10'd0,    32'd2300,       1'b1, EV_NONE,      2'd0}, // lowest sample, no match
    '{10'd700,  32'd2400,       1'b0, EV_NONE,      2'd0}, // long release key 2
    '{10'd49,   32'd2455,       1'b0, EV_NONE,      2'd0}, // latch nothing
    '{10'd49,   32'd4500,       1'b0, EV_NONE,      2'd0}, // pair 1+3 combo
    '{10'd1023, 32'd4600,       1'b0, EV_NONE,      2'd0}, // long release after combo
    '{10'd300,  32'd4655,       1'b0, EV_NONE,      2'd0}, // unmatched latch
    '{10'd300,  32'd4700,       1'b0, EV_NONE,      2'd0}, // pending, unmatched
    '{10'd651,  32'd4710,       1'b1, EV_HELD,      2'd0}, // release of unmatched latch
    '{10'd648,  32'd4720,       1'b0, EV_NONE,      2'd0}, // exactly on release bound
    '{10'd649,  32'd4730,       1'b0, EV_NONE,      2'd0}, // just above release bound
    '{10'd60,   32'd4781,       1'b0, EV_NONE,      2'd0}, // on match edge, excluded
    '{10'd59,   32'd4785,       1'b0, EV_NONE,      2'd0}, // inside match window
    '{10'd59,   32'd4790,       1'b0, EV_NONE,      2'd0}, // end of latch window
    '{10'd1023, 32'hFFFF_FFF0,  1'b1, EV_SHORT_REL, 2'd1}, // release near time wrap
    '{10'd221,  32'h0000_0023,  1'b0, EV_NONE,      2'd0}, // latch across the wrap
    '{10'd221,  32'h0000_0800,  1'b0, EV_NONE,      2'd0}, // long hold key 3
    '{10'd82,   32'h0000_0900,  1'b0, EV_NONE,      2'd0}, // pair level while held long
    '{10'd1023, 32'h0000_0950,  1'b0, EV_NONE,      2'd0}  // long release key 3
  };

  logic clk;
  logic rst_n;

  rlkd_in_if  in_chan ();
  rlkd_out_if out_chan ();
  rlkd_cfg_if cfg_chan ();

  resistor_ladder_key_decoder_top u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan),
    .cfg_chan (cfg_chan)
  );

  // Model registers and press state
  logic [REL_W-1:0]    lvl_release;
  logic [TOL_W-1:0]    lvl_tol;
  logic [MS_W-1:0]     ms_debounce;
  logic [MS_W-1:0]     ms_long;
  logic [LEVELS_W-1:0] key_levels;
  logic [LEVELS_W-1:0] pair_levels;
  logic [TIME_W-1:0]   hold_since;
  logic [1:0]          hold_phase;
  logic [CODE_W-1:0]   held_code;

  key_event_t  events_due[$];
  logic [31:0] clock_ms;
  int          samples_sent;
  int          events_seen;
  int          reg_writes;
  int          mismatches;
  int          kinds_seen[8];
  int          idle_cycles;
  bit          calm;
  bit          hold_off_req;

  initial clk = 1'b0;
  always #10 clk = ~clk;

  // First slot whose exclusive window holds the sample, 0 when none does
  function automatic logic [1:0] ladder_slot(input int s, input logic [LEVELS_W-1:0] levels);
    int lvl;
    int tol;
    tol = int'(lvl_tol);
    for (int i = 0; i < LEVEL_SLOTS; i++) begin
      lvl = int'(levels[i*LEVEL_BITS +: LEVEL_BITS]);
      if (s > lvl - tol && s < lvl + tol) return 2'(i + 1);
    end
    return 2'd0;
  endfunction

  // Advance the press state by one sample and return the event it reports
  function automatic key_event_t decode_sample(input logic [ADC_BITS-1:0] adc,
                                               input logic [TIME_W-1:0] now);
    int                s;
    logic [TIME_W-1:0] elapsed;
    logic [CODE_W-1:0] code;
    logic [1:0]        k;
    key_event_t        ev;
    s       = int'(adc);
    elapsed = now - hold_since;
    code    = CODE_NONE;
    k       = 2'd0;
    if (s > int'(lvl_release) - int'(lvl_tol)) begin
      hold_since = now;
      if (hold_phase == PH_SHORT) begin
        hold_phase = PH_IDLE;
        held_code  = held_code + CODE_HELD_BASE;
        code       = held_code;
      end else if (hold_phase == PH_LONG) begin
        hold_phase = PH_IDLE;
        code       = held_code;
      end
    end else if (elapsed > 32'(ms_long)) begin
      hold_phase = PH_LONG;
      if (held_code != CODE_NONE) begin
        k = ladder_slot(s, key_levels);
        if (k != 2'd0) begin
          held_code = CODE_LATCH_LONG + CODE_W'(k);
          code      = CODE_HOLD_BASE + CODE_W'(k);
        end
      end
      if (k == 2'd0 && held_code < CODE_LATCH_LONG) begin
        k = ladder_slot(s, pair_levels);
        if (k != 2'd0) begin
          held_code = CODE_NONE;
          code      = CODE_COMBO_BASE + CODE_W'(k);
        end
      end
    end else if (elapsed > 32'(ms_debounce) &&
                 elapsed < 32'(ms_debounce) + 32'(DEBOUNCE_WINDOW_MS)) begin
      hold_phase = PH_SHORT;
      k          = ladder_slot(s, key_levels);
      held_code  = (k != 2'd0) ? CODE_HELD_BASE + CODE_W'(k) : CODE_NONE;
    end else if (hold_phase == PH_SHORT) begin
      code = held_code;
    end
    ev.kind = KIND_W'(code / CODE_W'(CODE_STEP));
    ev.key  = KEY_W'(code % CODE_W'(CODE_STEP));
    return ev;
  endfunction

  // Offer one sample, possibly after a random gap, and predict its event
  task automatic send_sample(input logic [ADC_BITS-1:0] adc, input logic [TIME_W-1:0] now,
                             input bit typed = 1'b0,
                             input logic [KIND_W-1:0] t_kind = EV_NONE,
                             input logic [KEY_W-1:0] t_key = 2'd0);
    key_event_t ev;
    if (!calm && $urandom_range(0, 99) < 14) begin
      in_chan.valid = 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
    in_chan.valid      = 1'b1;
    in_chan.adc_sample = adc;
    in_chan.now_ms     = now;
    do @(posedge clk); while (!in_chan.ready);
    ev = decode_sample(adc, now);
    if (typed) begin
      ev.kind = t_kind;
      ev.key  = t_key;
    end
    events_due.push_back(ev);
    samples_sent++;
    @(negedge clk);
  endtask

  // Write one register and mirror it in the model, masked to its width
  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] data);
    cfg_chan.valid = 1'b1;
    cfg_chan.index = idx;
    cfg_chan.data  = data;
    do @(posedge clk); while (!cfg_chan.ready);
    case (idx)
      CFG_RELEASE_LEVEL:     lvl_release = data[REL_W-1:0];
      CFG_MATCH_TOLERANCE:   lvl_tol     = data[TOL_W-1:0];
      CFG_DEBOUNCE_MS:       ms_debounce = data[MS_W-1:0];
      CFG_LONG_PRESS_MS:     ms_long     = data[MS_W-1:0];
      CFG_SINGLE_KEY_LEVELS: key_levels  = data[LEVELS_W-1:0];
      CFG_COMBO_LEVELS:      pair_levels = data[LEVELS_W-1:0];
      default: ;
    endcase
    reg_writes++;
    @(negedge clk);
  endtask

  // Hold the sender until every predicted event has come out
  task automatic wait_for_events();
    in_chan.valid = 1'b0;
    while (events_due.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // One press: release, bounce, latch window, hold, long hold; stages are
  // skipped at random so that broken presses are mixed in.
  task automatic run_gesture();
    int          tol;
    int          thr;
    int          slot;
    int          lvl;
    int          p;
    int          hold_p;
    int          lo;
    int          hi;
    logic [31:0] t0;
    tol  = int'(lvl_tol);
    thr  = int'(lvl_release) - tol;
    slot = $urandom_range(0, LEVEL_SLOTS - 1);
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: lvl = int'(key_levels[slot*LEVEL_BITS +: LEVEL_BITS]);
      5, 6, 7:       lvl = int'(pair_levels[slot*LEVEL_BITS +: LEVEL_BITS]);
      default:       lvl = $urandom_range(0, 1023);
    endcase
    p = lvl;
    if (tol > 0) p = lvl + int'($urandom_range(0, 2 * tol - 2)) - (tol - 1);
    // land on the excluded edge of the window now and then
    if ($urandom_range(0, 7) == 0) p = $urandom_range(0, 1) ? lvl + tol : lvl - tol;
    if (p < 0) p = 0;
    if (p > 1023) p = 1023;
    slot   = $urandom_range(0, LEVEL_SLOTS - 1);
    hold_p = ($urandom_range(0, 3) == 0) ? int'(pair_levels[slot*LEVEL_BITS +: LEVEL_BITS]) : p;

    t0 = clock_ms;
    lo = (thr < 0) ? 0 : thr + 1;
    send_sample((thr < 1023) ? ADC_BITS'($urandom_range(lo, 1023)) : 10'd1023, t0);
    repeat ($urandom_range(0, 2)) send_sample(ADC_BITS'(p), t0 + $urandom_range(0, ms_debounce));
    if ($urandom_range(0, 6) != 0)
      repeat ($urandom_range(1, 2))
        send_sample(ADC_BITS'(p),
                    t0 + ms_debounce + $urandom_range(1, DEBOUNCE_WINDOW_MS - 1));
    lo = int'(ms_debounce) + DEBOUNCE_WINDOW_MS;
    hi = int'(ms_long);
    if (hi >= lo)
      repeat ($urandom_range(0, 3))
        send_sample(ADC_BITS'(p), t0 + $urandom_range(lo, hi));
    if ($urandom_range(0, 4) < 3)
      repeat ($urandom_range(1, 3))
        send_sample(ADC_BITS'(hold_p), t0 + ms_long + $urandom_range(1, 600));
    clock_ms = t0 + ms_long + 600 + $urandom_range(1, 2000);
    if ($urandom_range(0, 19) == 0) clock_ms = $urandom();
  endtask

  // Event receiver: random back-pressure, plus one long hold-off on request
  initial begin : event_sink
    int n;
    out_chan.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        out_chan.ready = 1'b0;
        for (n = 1; n < HOLD_OFF_CYCLES; n++) @(negedge clk);
        hold_off_req = 1'b0;
      end else begin
        out_chan.ready = calm || ($urandom_range(0, 99) >= 14);
      end
    end
  end

  // Check each event transfer against the oldest prediction
  always @(posedge clk) begin : event_check
    key_event_t ev;
    if (rst_n && out_chan.valid && out_chan.ready) begin
      events_seen++;
      kinds_seen[out_chan.event_kind]++;
      if (events_due.size() == 0) begin
        $display("%0t: event with none due: kind %0d key %0d",
                 $time, out_chan.event_kind, out_chan.key_number);
        mismatches++;
      end else begin
        ev = events_due.pop_front();
        if (out_chan.event_kind !== ev.kind || out_chan.key_number !== ev.key) begin
          $display("%0t: event mismatch: expected kind %0d key %0d, got kind %0d key %0d",
                   $time, ev.kind, ev.key, out_chan.event_kind, out_chan.key_number);
          mismatches++;
        end
      end
    end
  end

  // Watchdog: too long without any transfer on any channel ends the run
  always @(posedge clk) begin
    if (!rst_n || (in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready) ||
        (cfg_chan.valid && cfg_chan.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, idle_cycles);
      $display("resistor_ladder_key_decoder_top verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : stimulus
    int                  setting;
    bit                  paused;
    logic [REL_W-1:0]    rel;
    logic [TOL_W-1:0]    tol;
    logic [MS_W-1:0]     deb;
    logic [MS_W-1:0]     lng;
    logic [LEVELS_W-1:0] singles;
    logic [LEVELS_W-1:0] pairs;

    // drive every input to a known value before reset
    rst_n              = 1'b0;
    in_chan.valid      = 1'b0;
    in_chan.adc_sample = '0;
    in_chan.now_ms     = '0;
    cfg_chan.valid     = 1'b0;
    cfg_chan.index     = CFG_RELEASE_LEVEL;
    cfg_chan.data      = '0;
    calm               = 1'b0;
    hold_off_req       = 1'b0;
    paused             = 1'b0;
    idle_cycles        = 0;
    samples_sent       = 0;
    events_seen        = 0;
    reg_writes         = 0;
    mismatches         = 0;
    foreach (kinds_seen[i]) kinds_seen[i] = 0;

    // model state after reset
    lvl_release = RST_RELEASE_LEVEL;
    lvl_tol     = RST_MATCH_TOLERANCE;
    ms_debounce = RST_DEBOUNCE_MS;
    ms_long     = RST_LONG_PRESS_MS;
    key_levels  = RST_SINGLE_KEY_LEVELS;
    pair_levels = RST_COMBO_LEVELS;
    hold_since  = '0;
    hold_phase  = PH_IDLE;
    held_code   = CODE_NONE;

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed table under the reset settings
    foreach (DIRECTED_ROWS[i])
      send_sample(DIRECTED_ROWS[i].adc, DIRECTED_ROWS[i].now, DIRECTED_ROWS[i].typed,
                  DIRECTED_ROWS[i].kind, DIRECTED_ROWS[i].key);
    clock_ms = 32'h0000_1000;

    for (setting = 0; setting < N_SETTINGS; setting++) begin
      if (setting > 0) begin
        // drain before touching the registers
        wait_for_events();
        case (setting)
          1: begin
            // every register at its ceiling, written with all data bits set
            rel = '1; tol = '1; deb = '1; lng = '1; singles = '1; pairs = '1;
          end
          2: begin
            rel = '0; tol = '0; deb = '0; lng = '0; singles = '0; pairs = '0;
          end
          default: begin
            rel     = REL_W'($urandom_range(200, 1023));
            tol     = ($urandom_range(0, 4) == 0) ? 6'd63 : TOL_W'($urandom_range(1, 15));
            deb     = MS_W'($urandom_range(0, 400));
            lng     = MS_W'(deb + $urandom_range(0, 3000));
            singles = {10'($urandom_range(0, rel)), 10'($urandom_range(0, rel)),
                       10'($urandom_range(0, rel))};
            pairs   = {10'($urandom_range(0, rel)), 10'($urandom_range(0, rel)),
                       10'($urandom_range(0, rel))};
          end
        endcase
        // upper data bits are junk above each register's width
        write_register(CFG_RELEASE_LEVEL,
                       (setting == 1) ? '1 : {20'($urandom()), rel});
        write_register(CFG_MATCH_TOLERANCE,
                       (setting == 1) ? '1 : {24'($urandom()), tol});
        write_register(CFG_DEBOUNCE_MS, (setting == 1) ? '1 : {14'($urandom()), deb});
        write_register(CFG_LONG_PRESS_MS, (setting == 1) ? '1 : {14'($urandom()), lng});
        write_register(CFG_SINGLE_KEY_LEVELS, singles);
        write_register(CFG_COMBO_LEVELS, pairs);
        // writes to indexes with no register must change nothing
        write_register(CFG_SPARE_LO, CFG_DATA_W'($urandom()));
        write_register(CFG_SPARE_HI, CFG_DATA_W'($urandom()));
        cfg_chan.valid = 1'b0;
      end

      // one setting runs with no idling on either side
      calm = (setting == 3);
      // hold the receiver off while samples keep coming, so the block fills
      if (setting == 4) hold_off_req = 1'b1;

      while (samples_sent < $size(DIRECTED_ROWS) + (setting + 1) * SAMPLES_PER_SETUP) begin
        if (setting == 5 && !paused &&
            samples_sent > $size(DIRECTED_ROWS) + 5 * SAMPLES_PER_SETUP + 100) begin
          wait_for_events();
          paused = 1'b1;
        end
        if ($urandom_range(0, 99) < 15)
          send_sample(ADC_BITS'($urandom_range(0, 1023)), $urandom());
        else
          run_gesture();
      end
    end

    wait_for_events();

    $display("Covered %0d samples and %0d events over %0d settings with %0d register writes.",
             samples_sent, events_seen, N_SETTINGS, reg_writes);
    $display("Events by kind: none %0d, held %0d, short release %0d, long hold %0d, %s %0d, %s %0d",
             kinds_seen[EV_NONE], kinds_seen[EV_HELD], kinds_seen[EV_SHORT_REL],
             kinds_seen[EV_LONG_HOLD], "long release", kinds_seen[EV_LONG_REL],
             "combo", kinds_seen[EV_COMBO]);
    if (mismatches == 0) begin
      $display("resistor_ladder_key_decoder_top verification clean");
    end else begin
      $display("resistor_ladder_key_decoder_top verification failed");
    end
    $finish;
  end

endmodule
